// ----- rtl/landmark_affine_transform_macros.svh -----
// Assertion macros for the landmark affine transform.
// Used by the top level only; the bodies are empty when SYNTH is defined.
`ifndef LANDMARK_AFFINE_TRANSFORM_MACROS_SVH
`define LANDMARK_AFFINE_TRANSFORM_MACROS_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define LAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define LAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LAT_ASSERT_IMP(lbl, ante, cons, msg)
`define LAT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/lat_pkg.sv -----
// Shared types, constants and a helper function for the landmark affine transform.
// No dependencies; the modules, interfaces and testbench refer to it by scoped names.
package lat_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned CoordW      = 33;
  localparam int unsigned ProdW       = 65;
  localparam int unsigned AccW        = 67;
  localparam int unsigned SumW        = 52;
  localparam int unsigned DetW        = 50;
  localparam int unsigned DivW        = 51;
  localparam int unsigned PpsW        = 9;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 9;
  localparam int unsigned FifoDepth   = 2;
  localparam int unsigned FifoLvlW    = 2;
  localparam int unsigned MaxPointsDef = 256;

  localparam logic [PpsW-1:0]    PpsReset     = 9'd68;
  localparam logic [CfgIdxW-1:0] CfgIdxInvert = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgIdxPoints = 1'b1;
  localparam logic               ActLoad      = 1'b0;
  localparam logic               ActPoint     = 1'b1;

  // One input transaction as it sits in the queue.
  typedef struct packed {
    logic                    action;
    logic signed [DataW-1:0] m0;
    logic signed [DataW-1:0] m1;
    logic signed [DataW-1:0] m2;
    logic signed [DataW-1:0] m3;
    logic signed [DataW-1:0] tx;
    logic signed [DataW-1:0] ty;
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
  } item_t;

  // Queue entry: the item plus its class.
  typedef struct packed {
    logic  is_load;
    item_t item;
  } entry_t;

  // Queue status handed to the top level.
  typedef struct packed {
    logic [FifoLvlW-1:0] level;
    logic                full;
  } front_stat_t;

  // Saturate a wide signed sum to 32 bits.
  function automatic logic signed [DataW-1:0] sat32(input logic signed [SumW-1:0] v);
    logic signed [DataW-1:0] r;
    if (v > 52'sh7fffffff) begin
      r = 32'sh7fffffff;
    end else if (v < -52'sh80000000) begin
      r = -32'sh80000000;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/lat_in_if.sv -----
// Input channel interface of the landmark affine transform.
// Depends on lat_pkg for field widths.
interface lat_in_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic signed [lat_pkg::DataW-1:0] m0;
  logic signed [lat_pkg::DataW-1:0] m1;
  logic signed [lat_pkg::DataW-1:0] m2;
  logic signed [lat_pkg::DataW-1:0] m3;
  logic signed [lat_pkg::DataW-1:0] tx;
  logic signed [lat_pkg::DataW-1:0] ty;
  logic signed [lat_pkg::DataW-1:0] x;
  logic signed [lat_pkg::DataW-1:0] y;

  modport source (output valid, action, m0, m1, m2, m3, tx, ty, x, y, input ready);
  modport sink (input valid, action, m0, m1, m2, m3, tx, ty, x, y, output ready);
endinterface

// ----- rtl/lat_out_if.sv -----
// Result channel interface of the landmark affine transform.
// Depends on lat_pkg for field widths.
interface lat_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [lat_pkg::DataW-1:0] out_x;
  logic signed [lat_pkg::DataW-1:0] out_y;
  logic                             singular;
  logic                             last_point;

  modport source (output valid, out_x, out_y, singular, last_point, input ready);
  modport sink (input valid, out_x, out_y, singular, last_point, output ready);
endinterface

// ----- rtl/lat_cfg_if.sv -----
// Configuration write channel interface of the landmark affine transform.
// Depends on lat_pkg for index and data widths.
interface lat_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lat_pkg::CfgIdxW-1:0]     index;
  logic [lat_pkg::CfgDataW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/lat_front.sv -----
// Front end: accepts input transactions, classifies them and queues them.
// Depends on lat_pkg and lat_in_if.
module lat_front (
  input  logic                 clk,
  input  logic                 rst_n,
  lat_in_if.sink               in_ch,
  output lat_pkg::entry_t      pop_entry,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output lat_pkg::front_stat_t stat
);

  lat_pkg::entry_t              mem_r [lat_pkg::FifoDepth];
  logic                         wr_ptr_r;
  logic                         rd_ptr_r;
  logic [lat_pkg::FifoLvlW-1:0] level_r;
  logic                         push;
  logic                         pop;
  lat_pkg::entry_t              new_entry;

  // Accept while the queue has room.
  assign in_ch.ready = (level_r != lat_pkg::FifoLvlW'(lat_pkg::FifoDepth));
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = pop_valid && pop_ready;
  assign pop_valid   = (level_r != '0);
  assign pop_entry   = mem_r[rd_ptr_r];

  // Classify the incoming transaction.
  always_comb begin
    new_entry.is_load     = (in_ch.action == lat_pkg::ActLoad);
    new_entry.item.action = in_ch.action;
    new_entry.item.m0     = in_ch.m0;
    new_entry.item.m1     = in_ch.m1;
    new_entry.item.m2     = in_ch.m2;
    new_entry.item.m3     = in_ch.m3;
    new_entry.item.tx     = in_ch.tx;
    new_entry.item.ty     = in_ch.ty;
    new_entry.item.x      = in_ch.x;
    new_entry.item.y      = in_ch.y;
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_entry;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        level_r <= level_r + 1'b1;
      end else if (pop && !push) begin
        level_r <= level_r - 1'b1;
      end
    end
  end

  assign stat.level = level_r;
  assign stat.full  = !in_ch.ready;

endmodule

// ----- rtl/lat_div.sv -----
// Restoring divider for the inverse coefficients: one quotient bit per cycle,
// rounded half away from zero and saturated to 32 bits. Depends on lat_pkg.
module lat_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [lat_pkg::CoordW-1:0]  num,
  input  logic signed [lat_pkg::DetW-1:0]    den,
  output logic                               done,
  output logic signed [lat_pkg::DataW-1:0]   quo
);

  localparam int unsigned DivW = lat_pkg::DivW;
  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0]              dvd_r;
  logic [DivW-1:0]              dvs_r;
  logic [DivW-1:0]              rem_r;
  logic [DivW-1:0]              q_r;
  logic [CntW-1:0]              cnt_r;
  logic                         busy_r;
  logic                         neg_r;
  logic                         done_r;
  logic [lat_pkg::CoordW-1:0]   abs_n;
  logic [lat_pkg::DetW-1:0]     abs_d;
  logic [DivW:0]                trial;
  logic                         fits;

  assign abs_n = num[lat_pkg::CoordW-1] ? lat_pkg::CoordW'(-num) : lat_pkg::CoordW'(num);
  assign abs_d = den[lat_pkg::DetW-1] ? lat_pkg::DetW'(-den) : lat_pkg::DetW'(den);
  assign trial = {rem_r, dvd_r[DivW-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  // Operand setup and one subtract step per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= (DivW'(abs_n) << 17) + DivW'(abs_d);
      dvs_r <= DivW'(abs_d) << 1;
      rem_r <= '0;
      q_r   <= '0;
      neg_r <= num[lat_pkg::CoordW-1] ^ den[lat_pkg::DetW-1];
    end else if (busy_r) begin
      rem_r <= fits ? DivW'(trial - {1'b0, dvs_r}) : trial[DivW-1:0];
      q_r   <= {q_r[DivW-2:0], fits};
      dvd_r <= dvd_r << 1;
    end
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == CntW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(DivW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Saturate and apply the sign.
  always_comb begin
    if (neg_r) begin
      if (q_r >= DivW'(64'h80000000)) begin
        quo = -32'sh80000000;
      end else begin
        quo = -$signed(q_r[lat_pkg::DataW-1:0]);
      end
    end else if (q_r > DivW'(64'h7fffffff)) begin
      quo = 32'sh7fffffff;
    end else begin
      quo = $signed(q_r[lat_pkg::DataW-1:0]);
    end
  end

  assign done = done_r;

endmodule

// ----- rtl/lat_exec.sv -----
// Back end: holds the transform and configuration, runs loads and points on
// two shared multipliers and the divider, and drives the result register.
// Depends on lat_pkg, lat_cfg_if, lat_out_if and lat_div.
module lat_exec #(
  parameter int unsigned MAX_POINTS = lat_pkg::MaxPointsDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lat_pkg::entry_t pop_entry,
  input  logic            pop_valid,
  output logic            pop_ready,
  lat_cfg_if.sink         cfg_ch,
  lat_out_if.source       out_ch
);

  localparam int unsigned CntW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CmpW = ((CntW > lat_pkg::PpsW) ? CntW : lat_pkg::PpsW) + 1;
  localparam int unsigned DataW = lat_pkg::DataW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PMUL1 = 4'd1;
  localparam logic [3:0] S_PMUL2 = 4'd2;
  localparam logic [3:0] S_PFIN  = 4'd3;
  localparam logic [3:0] S_DMUL  = 4'd4;
  localparam logic [3:0] S_DDET  = 4'd5;
  localparam logic [3:0] S_DGO   = 4'd6;
  localparam logic [3:0] S_DWAIT = 4'd7;

  logic [3:0]                          state_r;
  logic [3:0]                          state_nxt;
  logic signed [DataW-1:0]             c_r [4];
  logic signed [DataW-1:0]             s_r [2];
  logic                                sing_r;
  logic [CntW-1:0]                     cnt_r;
  logic                                inv_r;
  logic [lat_pkg::PpsW-1:0]            pps_r;
  logic signed [lat_pkg::CoordW-1:0]   x_r;
  logic signed [lat_pkg::CoordW-1:0]   y_r;
  logic signed [DataW-1:0]             bias_a_r;
  logic signed [DataW-1:0]             bias_b_r;
  logic                                dest_shift_r;
  logic                                pend_last_r;
  logic                                pend_sing_r;
  lat_pkg::item_t                      ld_r;
  logic signed [lat_pkg::ProdW-1:0]    pa_r;
  logic signed [lat_pkg::ProdW-1:0]    pb_r;
  logic signed [lat_pkg::ProdW-1:0]    qa_r;
  logic signed [lat_pkg::ProdW-1:0]    qb_r;
  logic signed [lat_pkg::DetW-1:0]     det_r;
  logic [1:0]                          div_idx_r;
  logic                                ov_r;
  logic signed [DataW-1:0]             ox_r;
  logic signed [DataW-1:0]             oy_r;
  logic                                osing_r;
  logic                                olast_r;

  logic                                take;
  logic                                out_free;
  logic signed [lat_pkg::CoordW-1:0]   mla_a;
  logic signed [lat_pkg::CoordW-1:0]   mlb_a;
  logic signed [DataW-1:0]             mla_b;
  logic signed [DataW-1:0]             mlb_b;
  logic signed [lat_pkg::ProdW-1:0]    prod_a;
  logic signed [lat_pkg::ProdW-1:0]    prod_b;
  logic signed [lat_pkg::AccW-1:0]     acc_a;
  logic signed [lat_pkg::AccW-1:0]     acc_b;
  logic signed [lat_pkg::AccW-1:0]     acc_d;
  logic signed [lat_pkg::SumW-1:0]     sum_a;
  logic signed [lat_pkg::SumW-1:0]     sum_b;
  logic signed [DataW-1:0]             res_a;
  logic signed [DataW-1:0]             res_b;
  logic signed [lat_pkg::DetW-1:0]     det_nxt;
  logic [CmpW-1:0]                     count;
  logic                                last;
  logic                                div_start;
  logic                                div_done;
  logic signed [lat_pkg::CoordW-1:0]   div_num;
  logic signed [DataW-1:0]             div_quo;

  assign pop_ready = (state_r == S_IDLE);
  assign take      = pop_valid && pop_ready;
  assign out_free  = !ov_r || out_ch.ready;
  assign div_start = (state_r == S_DGO);

  // Set length clamped to one through MAX_POINTS, and the last-point test.
  always_comb begin
    count = CmpW'(pps_r);
    if (count == '0) begin
      count = CmpW'(1);
    end else if (count > CmpW'(MAX_POINTS)) begin
      count = CmpW'(MAX_POINTS);
    end
    last = ((CmpW'(cnt_r) + CmpW'(1)) >= count);
  end

  // Operand selection for the two multiplier lanes.
  always_comb begin
    case (state_r)
      S_PMUL2: begin
        mla_a = y_r;
        mla_b = c_r[2];
        mlb_a = y_r;
        mlb_b = c_r[3];
      end
      S_DMUL: begin
        mla_a = lat_pkg::CoordW'(ld_r.m0);
        mla_b = ld_r.m3;
        mlb_a = lat_pkg::CoordW'(ld_r.m1);
        mlb_b = ld_r.m2;
      end
      default: begin
        mla_a = x_r;
        mla_b = c_r[0];
        mlb_a = x_r;
        mlb_b = c_r[1];
      end
    endcase
    prod_a = lat_pkg::ProdW'(mla_a) * lat_pkg::ProdW'(mla_b);
    prod_b = lat_pkg::ProdW'(mlb_a) * lat_pkg::ProdW'(mlb_b);
  end

  // Rounding, bias and saturation of the two dot products; determinant.
  always_comb begin
    acc_a   = lat_pkg::AccW'(pa_r) + lat_pkg::AccW'(qa_r) + 67'sd32768;
    acc_b   = lat_pkg::AccW'(pb_r) + lat_pkg::AccW'(qb_r) + 67'sd32768;
    sum_a   = lat_pkg::SumW'(acc_a >>> 16) + lat_pkg::SumW'(bias_a_r);
    sum_b   = lat_pkg::SumW'(acc_b >>> 16) + lat_pkg::SumW'(bias_b_r);
    res_a   = lat_pkg::sat32(sum_a);
    res_b   = lat_pkg::sat32(sum_b);
    acc_d   = lat_pkg::AccW'(pa_r) - lat_pkg::AccW'(pb_r) + 67'sd32768;
    det_nxt = lat_pkg::DetW'(acc_d >>> 16);
  end

  // Numerator of the current inverse coefficient.
  always_comb begin
    case (div_idx_r)
      2'd0:    div_num = lat_pkg::CoordW'(ld_r.m3);
      2'd1:    div_num = -lat_pkg::CoordW'(ld_r.m1);
      2'd2:    div_num = -lat_pkg::CoordW'(ld_r.m2);
      default: div_num = lat_pkg::CoordW'(ld_r.m0);
    endcase
  end

  lat_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (det_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (take && !pop_entry.is_load) begin
          state_nxt = S_PMUL1;
        end else if (take && inv_r) begin
          state_nxt = S_DMUL;
        end
      end
      S_PMUL1: state_nxt = S_PMUL2;
      S_PMUL2: state_nxt = S_PFIN;
      S_PFIN: begin
        if (dest_shift_r || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DMUL: state_nxt = S_DDET;
      S_DDET: state_nxt = (det_nxt == '0) ? S_IDLE : S_DGO;
      S_DGO:  state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (div_done) begin
          state_nxt = (div_idx_r == 2'd3) ? S_PMUL1 : S_DGO;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Working registers of the current transaction.
  always_ff @(posedge clk) begin
    if (state_r == S_PMUL1 || state_r == S_DMUL) begin
      pa_r <= prod_a;
      pb_r <= prod_b;
    end
    if (state_r == S_PMUL2) begin
      qa_r <= prod_a;
      qb_r <= prod_b;
    end
    if (state_r == S_DDET) begin
      det_r <= det_nxt;
    end
    if (take) begin
      ld_r        <= pop_entry.item;
      x_r         <= lat_pkg::CoordW'(pop_entry.item.x);
      y_r         <= lat_pkg::CoordW'(pop_entry.item.y);
      bias_a_r    <= s_r[0];
      bias_b_r    <= s_r[1];
      pend_last_r <= last;
      pend_sing_r <= sing_r;
    end else if (state_r == S_DWAIT && div_done && div_idx_r == 2'd3) begin
      // The shift is the negated translation pushed through the new inverse.
      x_r      <= -lat_pkg::CoordW'(ld_r.tx);
      y_r      <= -lat_pkg::CoordW'(ld_r.ty);
      bias_a_r <= '0;
      bias_b_r <= '0;
    end
  end

  // Sequencer, stored transform, point counter and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      c_r[0]       <= '0;
      c_r[1]       <= '0;
      c_r[2]       <= '0;
      c_r[3]       <= '0;
      s_r[0]       <= '0;
      s_r[1]       <= '0;
      sing_r       <= 1'b0;
      cnt_r        <= '0;
      inv_r        <= 1'b0;
      pps_r        <= lat_pkg::PpsReset;
      dest_shift_r <= 1'b0;
      div_idx_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          lat_pkg::CfgIdxInvert: inv_r <= cfg_ch.data[0];
          lat_pkg::CfgIdxPoints: pps_r <= cfg_ch.data[lat_pkg::PpsW-1:0];
          default: ;
        endcase
      end
      if (take && pop_entry.is_load) begin
        cnt_r     <= '0;
        div_idx_r <= '0;
        if (!inv_r) begin
          c_r[0] <= pop_entry.item.m0;
          c_r[1] <= pop_entry.item.m1;
          c_r[2] <= pop_entry.item.m2;
          c_r[3] <= pop_entry.item.m3;
          s_r[0] <= pop_entry.item.tx;
          s_r[1] <= pop_entry.item.ty;
          sing_r <= 1'b0;
        end
      end else if (take) begin
        dest_shift_r <= 1'b0;
        cnt_r        <= last ? '0 : CntW'(cnt_r + 1'b1);
      end
      // A determinant that rounds to zero leaves an all-zero transform.
      if (state_r == S_DDET && det_nxt == '0) begin
        c_r[0] <= '0;
        c_r[1] <= '0;
        c_r[2] <= '0;
        c_r[3] <= '0;
        s_r[0] <= '0;
        s_r[1] <= '0;
        sing_r <= 1'b1;
      end
      if (state_r == S_DWAIT && div_done) begin
        c_r[div_idx_r] <= div_quo;
        div_idx_r      <= div_idx_r + 1'b1;
        if (div_idx_r == 2'd3) begin
          dest_shift_r <= 1'b1;
        end
      end
      if (state_r == S_PFIN && dest_shift_r) begin
        s_r[0] <= res_a;
        s_r[1] <= res_b;
        sing_r <= 1'b0;
      end
    end
  end

  // Result register: a finished point waits here while work goes on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (state_r == S_PFIN && !dest_shift_r && out_free) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PFIN && !dest_shift_r && out_free) begin
      ox_r    <= pend_sing_r ? '0 : res_a;
      oy_r    <= pend_sing_r ? '0 : res_b;
      osing_r <= pend_sing_r;
      olast_r <= pend_last_r;
    end
  end

  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = ov_r;
  assign out_ch.out_x      = ox_r;
  assign out_ch.out_y      = oy_r;
  assign out_ch.singular   = osing_r;
  assign out_ch.last_point = olast_r;

endmodule

// ----- rtl/landmark_affine_transform.sv -----
// Landmark affine transform, top level: a queue front end and an execution back end.
// A point transaction passes through the queue and then the back end: two multiplier passes
// (S_PMUL1, S_PMUL2) and a rounding step (S_PFIN) that fills the result register. The back
// end takes a new point only when it is back in S_IDLE. A direct load is taken in S_IDLE; an
// inverse load runs four 51-step divisions in the shared divider. Reset (rst_n
// low, synchronous) clears the queue, the transform, the counter and the configuration.
`include "landmark_affine_transform_macros.svh"
module landmark_affine_transform #(
  parameter int unsigned MAX_POINTS = lat_pkg::MaxPointsDef
) (
  input logic       clk,
  input logic       rst_n,
  lat_in_if.sink    in_ch,
  lat_out_if.source out_ch,
  lat_cfg_if.sink   cfg_ch
);

  lat_pkg::entry_t      pop_entry;
  logic                 pop_valid;
  logic                 pop_ready;
  lat_pkg::front_stat_t fstat;

  // Front end: accept and classify.
  lat_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .pop_entry (pop_entry),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .stat      (fstat)
  );

  // Back end: execute loads and points.
  lat_exec #(
    .MAX_POINTS (MAX_POINTS)
  ) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_entry (pop_entry),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .cfg_ch    (cfg_ch),
    .out_ch    (out_ch)
  );

  // A singular set only ever gives the zero point.
  `LAT_ASSERT_IMP(a_sing_zero, out_ch.valid && out_ch.singular, (out_ch.out_x == '0) && (out_ch.out_y == '0), "singular result is not zero")
  // The queue never holds more than its depth.
  `LAT_ASSERT_IMP(a_lvl_max, 1'b1, fstat.level <= lat_pkg::FifoLvlW'(lat_pkg::FifoDepth), "queue overfilled")
  // Without a transaction on either side the queue level holds.
  `LAT_ASSERT_NXT(a_lvl_hold, !(in_ch.valid && in_ch.ready) && !(pop_valid && pop_ready), $stable(fstat.level), "queue level changed without a transaction")

endmodule

// ----- tb/lat_tb_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the landmark affine transform: watches the input, result and
// configuration channels, predicts each point transaction and compares. Needs lat_pkg.
module lat_tb_checker (
  input  logic        clk,
  input  logic        rst_n,
  lat_in_if.sink      in_mon,
  lat_out_if.sink     out_mon,
  lat_cfg_if.sink     cfg_mon,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               sing;
    logic               last;
  } point_res_t;

  point_res_t          expected_points[$];
  logic                inv_mode;
  logic [8:0]          set_len;
  logic signed [31:0]  coef[4];
  logic signed [31:0]  shift[2];
  logic                sing_flag;
  logic [8:0]          pt_count;

  assign pending = expected_points.size();

  function automatic logic signed [63:0] floor_q16(input logic signed [63:0] v);
    return v >>> 16;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sh7fffffff) return 32'sh7fffffff;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Two products summed, rounded half up to Q16.16, plus a bias, saturated.
  function automatic logic signed [31:0] mac2(input logic signed [63:0] a, b, c, d, bias);
    logic signed [63:0] p1, p2, s;
    logic [63:0]        lows;
    p1 = a * b;
    p2 = c * d;
    lows = {48'd0, p1[15:0]} + {48'd0, p2[15:0]} + 64'd32768;
    s = floor_q16(p1) + floor_q16(p2) + bias + $signed(lows >> 16);
    return clamp32(s);
  endfunction

  // Q16.16 quotient rounded half away from zero, saturated.
  function automatic logic signed [31:0] qdivide(input logic signed [63:0] num, den);
    logic [63:0] un, ud, q;
    logic        neg;
    un = (num < 0 ? -num : num) << 16;
    ud = den < 0 ? -den : den;
    q = (2 * un + ud) / (2 * ud);
    neg = (num < 0) != (den < 0);
    if (neg) begin
      if (q > 64'h80000000) q = 64'h80000000;
      return clamp32(-$signed(q));
    end
    if (q > 64'h7fffffff) q = 64'h7fffffff;
    return q[31:0];
  endfunction

  task automatic load_transform(input logic signed [63:0] m0, m1, m2, m3, tx, ty);
    logic signed [63:0] p03, p12, lo, det;
    pt_count = 0;
    if (!inv_mode) begin
      coef[0] = m0[31:0]; coef[1] = m1[31:0]; coef[2] = m2[31:0]; coef[3] = m3[31:0];
      shift[0] = tx[31:0]; shift[1] = ty[31:0];
      sing_flag = 1'b0;
      return;
    end
    p03 = m0 * m3;
    p12 = m1 * m2;
    lo = $signed({48'd0, p03[15:0]}) - $signed({48'd0, p12[15:0]});
    det = floor_q16(p03) - floor_q16(p12) + floor_q16(lo + 32768);
    if (det == 0) begin
      foreach (coef[i]) coef[i] = '0;
      shift[0] = '0; shift[1] = '0;
      sing_flag = 1'b1;
      return;
    end
    coef[0] = qdivide(m3, det);
    coef[1] = qdivide(-m1, det);
    coef[2] = qdivide(-m2, det);
    coef[3] = qdivide(m0, det);
    shift[0] = mac2(-tx, coef[0], -ty, coef[2], 0);
    shift[1] = mac2(-tx, coef[1], -ty, coef[3], 0);
    sing_flag = 1'b0;
  endtask

  function automatic point_res_t map_point(input logic signed [63:0] x, y);
    point_res_t r;
    int unsigned n;
    n = set_len;
    if (n < 1) n = 1;
    if (n > 256) n = 256;
    if (sing_flag) begin
      r.px = '0; r.py = '0;
    end else begin
      r.px = mac2(x, coef[0], y, coef[2], shift[0]);
      r.py = mac2(x, coef[1], y, coef[3], shift[1]);
    end
    r.sing = sing_flag;
    r.last = (pt_count + 1 >= n);
    pt_count = r.last ? 9'd0 : pt_count + 9'd1;
    return r;
  endfunction

  // Track every transaction on all three channels at the rising edge.
  always @(posedge clk) begin
    point_res_t e;
    if (!rst_n) begin
      inv_mode <= 1'b0;
      set_len = lat_pkg::PpsReset;
      foreach (coef[i]) coef[i] = '0;
      shift[0] = '0; shift[1] = '0;
      sing_flag = 1'b0;
      pt_count = '0;
      fail_count <= 0;
      expected_points.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == lat_pkg::CfgIdxInvert) inv_mode <= cfg_mon.data[0];
        else set_len = cfg_mon.data;
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.action == lat_pkg::ActLoad)
          load_transform(in_mon.m0, in_mon.m1, in_mon.m2, in_mon.m3, in_mon.tx, in_mon.ty);
        else
          expected_points.push_back(map_point(in_mon.x, in_mon.y));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_points.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("Unexpected result x=%h y=%h", out_mon.out_x,
                                        out_mon.out_y);
        end else begin
          e = expected_points.pop_front();
          if (out_mon.out_x !== e.px || out_mon.out_y !== e.py ||
              out_mon.singular !== e.sing || out_mon.last_point !== e.last) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("Result differs: expected x=%h y=%h s=%b l=%b, got x=%h y=%h s=%b l=%b",
                       e.px, e.py, e.sing, e.last, out_mon.out_x, out_mon.out_y,
                       out_mon.singular, out_mon.last_point);
          end
        end
      end
    end
  end

endmodule

// ----- tb/landmark_affine_transform_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the landmark affine transform: makes stimulus, drives the block
// and the checker, and reports the verdict. Needs lat_pkg, the interfaces and the checker.
module landmark_affine_transform_tb;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned LoadDrain  = 300;
  localparam int unsigned HoldLen    = 200;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  logic        rx_stall_pattern = 1'b0;

  lat_in_if  in_ch ();
  lat_out_if out_ch ();
  lat_cfg_if cfg_ch ();

  landmark_affine_transform u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  lat_tb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: a stall pattern of its own, plus one long hold-off when requested.
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cycles <= HoldLen;
      out_ch.ready <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      rx_stall_pattern <= ($urandom_range(0, 63) < 8) ? ~rx_stall_pattern : rx_stall_pattern;
      out_ch.ready <= rx_stall_pattern ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
      4: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
      5: return $signed($urandom_range(0, 32'h1ff)) - 32'sh100;
      default: return $urandom;
    endcase
  endfunction

  // Offer one transaction and wait for its acceptance.
  task automatic send_item(input logic act, input logic [31:0] m0, m1, m2, m3, tx, ty, x, y);
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.m0 <= m0; in_ch.m1 <= m1; in_ch.m2 <= m2; in_ch.m3 <= m3;
    in_ch.tx <= tx; in_ch.ty <= ty; in_ch.x <= x; in_ch.y <= y;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    in_ch.valid <= 1'b0;
  endtask

  task automatic send_load(input logic [31:0] m0, m1, m2, m3, tx, ty);
    send_item(lat_pkg::ActLoad, m0, m1, m2, m3, tx, ty, $urandom, $urandom);
  endtask

  task automatic send_point(input logic [31:0] x, y);
    send_item(lat_pkg::ActPoint, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              x, y);
  endtask

  // Register write while idle: drain results and any load still in progress.
  task automatic write_reg(input logic [lat_pkg::CfgIdxW-1:0] idx, input logic [8:0] val);
    pause_sender();
    while (pending != 0) @(negedge clk);
    repeat (LoadDrain) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // A random set: a load, then points, with bursts and gaps.
  task automatic random_set(input int unsigned npts);
    logic [31:0] a, d;
    a = rand_word();
    d = rand_word();
    if ($urandom_range(0, 9) == 0) send_load(a, a, a, a, rand_word(), rand_word());
    else send_load(a, rand_word(), rand_word(), d, rand_word(), rand_word());
    for (int i = 0; i < npts; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        pause_sender();
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      send_point(rand_word(), rand_word());
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned lens[4];
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.action = lat_pkg::ActLoad;
    in_ch.m0 = '0; in_ch.m1 = '0; in_ch.m2 = '0; in_ch.m3 = '0;
    in_ch.tx = '0; in_ch.ty = '0; in_ch.x = '0; in_ch.y = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = lat_pkg::CfgIdxInvert; cfg_ch.data = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed: a point before any load, extremes, direct and inverse, singular.
    send_point(32'h7fffffff, 32'h80000000);
    write_reg(lat_pkg::CfgIdxPoints, 9'd3);
    send_load(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
              32'h80000000);
    send_point(32'h7fffffff, 32'h7fffffff);
    send_point(32'h80000000, 32'h80000000);
    send_point(32'h00010000, 32'hffff0000);
    send_point(32'h0, 32'hffffffff);
    write_reg(lat_pkg::CfgIdxInvert, 9'd1);
    send_load(32'h00020000, 32'h00000000, 32'h00000000, 32'h00020000, 32'h00010000,
              32'hffff0000);
    send_point(32'h00010000, 32'h00010000);
    send_load(32'h00010000, 32'h00020000, 32'h00008000, 32'h00010000, 32'h5, 32'h7);
    send_point(32'h12345678, 32'h9abcdef0);
    send_load(32'h00000001, 32'h1, 32'h1, 32'h1, 32'h7fffffff, 32'h80000000);
    send_point(32'h7fffffff, 32'h80000000);
    send_load(32'h80000000, 32'h7fffffff, 32'h1, 32'h80000000, 32'h80000000, 32'h7fffffff);
    send_point(32'h7fffffff, 32'h7fffffff);
    write_reg(lat_pkg::CfgIdxPoints, 9'd1);
    send_load(32'h00000100, 32'h0, 32'h0, 32'h00000100, 32'h0, 32'h0);
    send_point(32'h00010000, 32'h1);
    send_point(32'h1, 32'h1);
    write_reg(lat_pkg::CfgIdxPoints, 9'd0);
    send_point(32'h1, 32'h2);
    write_reg(lat_pkg::CfgIdxPoints, 9'd511);
    send_point(32'h3, 32'h4);

    // Receiver holds off while the sender keeps offering transactions.
    write_reg(lat_pkg::CfgIdxInvert, 9'd0);
    hold_req = 1'b1;
    send_load(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
    for (int i = 0; i < 20; i++) send_point(rand_word(), rand_word());

    // Random phases through several settings, alternating direct and inverse mode.
    lens = '{1, 5, 256, 68};
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(lat_pkg::CfgIdxInvert, {8'd0, ph[0]});
      write_reg(lat_pkg::CfgIdxPoints, 9'($urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                                     : lens[ph % 4]));
      while (sent < (ph + 1) * 170) begin
        n = $urandom_range(0, 3) == 0 ? $urandom_range(100, 300) : $urandom_range(1, 12);
        random_set(n);
        sent += n + 1;
      end
    end
    pause_sender();

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
